FILE: rtl/utc_pkg.sv
// ----------------------------------------------------------------------------
// utc_pkg
// Shared types and constants for the UTC date-time normalizer.
// ----------------------------------------------------------------------------
package utc_pkg;

   localparam int unsigned DIV_W  = 17;
   localparam int unsigned DIVR_W = 9;
   localparam int unsigned MAG_W  = 18;
   localparam int unsigned SHF_W  = 5;
   localparam int unsigned PROD_W = DIV_W + MAG_W;

   // divider operand select
   localparam logic [2:0] DIV_SEC  = 3'd0;
   localparam logic [2:0] DIV_MIN  = 3'd1;
   localparam logic [2:0] DIV_HOUR = 3'd2;
   localparam logic [2:0] DIV_MON  = 3'd3;
   localparam logic [2:0] DIV_YEAR = 3'd4;

   localparam logic [DIVR_W-1:0] DVS_MINUTE = 9'd60;
   localparam logic [DIVR_W-1:0] DVS_DAY    = 9'd24;
   localparam logic [DIVR_W-1:0] DVS_YEAR   = 9'd12;
   localparam logic [DIVR_W-1:0] DVS_CYCLE  = 9'd400;

   // reciprocals: quotient = (dividend * MAG) >> SHF, exact for any 17-bit dividend
   localparam logic [MAG_W-1:0] MAG_MINUTE = 18'd139811;
   localparam logic [SHF_W-1:0] SHF_MINUTE = 5'd23;
   localparam logic [MAG_W-1:0] MAG_DAY    = 18'd174763;
   localparam logic [SHF_W-1:0] SHF_DAY    = 5'd22;
   localparam logic [MAG_W-1:0] MAG_YEAR   = 18'd174763;
   localparam logic [SHF_W-1:0] SHF_YEAR   = 5'd21;
   localparam logic [MAG_W-1:0] MAG_CYCLE  = 18'd167773;
   localparam logic [SHF_W-1:0] SHF_CYCLE  = 5'd26;

   // offsets that make the dividend non-negative, and the matching quotient bias
   localparam logic signed [17:0] OFS_60    = 18'sd61440;
   localparam logic signed [17:0] BIAS_60   = 18'sd1024;
   localparam logic signed [17:0] OFS_24    = 18'sd49152;
   localparam logic signed [17:0] BIAS_24   = 18'sd2048;
   localparam logic signed [17:0] OFS_12    = 18'sd6144;
   localparam logic signed [17:0] BIAS_12   = 18'sd512;
   localparam logic signed [17:0] OFS_CYCLE = 18'sd27500;  // 1900 + 64 * 400

   localparam logic [8:0] YMOD_LAST = 9'd399;
   localparam logic [8:0] YMOD_C1   = 9'd100;
   localparam logic [8:0] YMOD_C2   = 9'd200;
   localparam logic [8:0] YMOD_C3   = 9'd300;

   localparam logic [3:0] MON_JAN = 4'd0;
   localparam logic [3:0] MON_FEB = 4'd1;
   localparam logic [3:0] MON_JUN = 4'd5;
   localparam logic [3:0] MON_JUL = 4'd6;
   localparam logic [3:0] MON_DEC = 4'd11;

   typedef struct packed {
      logic       load;
      logic       div_start;
      logic       commit;
      logic [2:0] div_sel;
      logic       step;
      logic       out_load;
   } dp_cmd_type;

   typedef struct packed {
      logic div_done;
      logic norm_done;
      logic out_free;
   } dp_status_type;

   function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
      logic [4:0] len;
      case (m)
         4'd1:    len = leap ? 5'd29 : 5'd28;
         4'd3:    len = 5'd30;
         4'd5:    len = 5'd30;
         4'd8:    len = 5'd30;
         4'd10:   len = 5'd30;
         default: len = 5'd31;
      endcase
      return len;
   endfunction

endpackage

FILE: rtl/utc_if.sv
// ----------------------------------------------------------------------------
// utc_if
// Valid/ready channels for date-time request and response words.
// ----------------------------------------------------------------------------
interface utc_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] sec_in;
   logic signed [15:0] min_in;
   logic signed [15:0] hour_in;
   logic signed [15:0] mday_in;
   logic signed [12:0] mon_in;
   logic signed [14:0] year_in;
   logic               leap_second_valid;

   modport source (output valid, sec_in, min_in, hour_in, mday_in, mon_in, year_in,
                   leap_second_valid, input ready);
   modport sink (input valid, sec_in, min_in, hour_in, mday_in, mon_in, year_in,
                 leap_second_valid, output ready);
endinterface

interface utc_rsp_if;
   logic               valid;
   logic               ready;
   logic [5:0]         sec_out;
   logic [5:0]         min_out;
   logic [4:0]         hour_out;
   logic [4:0]         mday_out;
   logic [3:0]         mon_out;
   logic signed [15:0] year_out;

   modport source (output valid, sec_out, min_out, hour_out, mday_out, mon_out, year_out,
                   input ready);
   modport sink (input valid, sec_out, min_out, hour_out, mday_out, mon_out, year_out,
                 output ready);
endinterface

FILE: rtl/utc_divider.sv
// ----------------------------------------------------------------------------
// utc_divider
// Floor quotient and remainder by a small constant divisor through reciprocal
// multiplication: operand capture, product, quotient, remainder.
// ----------------------------------------------------------------------------
module utc_divider import utc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DIV_W-1:0]  dividend,
   input  logic [DIVR_W-1:0] divisor,
   input  logic [MAG_W-1:0]  magic,
   input  logic [SHF_W-1:0]  shift,
   output logic              done,
   output logic [DIV_W-1:0]  quot,
   output logic [DIVR_W-1:0] rem
);

   logic [3:0]        stage_ff, stage_in;
   logic [DIV_W-1:0]  num_ff, num_in;
   logic [DIVR_W-1:0] dvs_ff, dvs_in;
   logic [MAG_W-1:0]  mag_ff, mag_in;
   logic [SHF_W-1:0]  shf_ff, shf_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [DIV_W-1:0]  quot_ff, quot_in;
   logic [DIVR_W-1:0] rem_ff, rem_in;
   logic [DIV_W-1:0]  back;

   assign back = quot_ff * DIV_W'(dvs_ff);

   always_comb begin
      stage_in = {stage_ff[2:0], start};
      num_in   = num_ff;
      dvs_in   = dvs_ff;
      mag_in   = mag_ff;
      shf_in   = shf_ff;
      if (start) begin
         num_in = dividend;
         dvs_in = divisor;
         mag_in = magic;
         shf_in = shift;
      end
      prod_in = PROD_W'(num_ff) * PROD_W'(mag_ff);
      quot_in = DIV_W'(prod_ff >> shf_ff);
      rem_in  = DIVR_W'(num_ff - back);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= '0;
      end else begin
         stage_ff <= stage_in;
      end
      num_ff  <= num_in;
      dvs_ff  <= dvs_in;
      mag_ff  <= mag_in;
      shf_ff  <= shf_in;
      prod_ff <= prod_in;
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
   end

   assign done = stage_ff[3];
   assign quot = quot_ff;
   assign rem  = rem_ff;

endmodule

FILE: rtl/utc_datapath.sv
// ----------------------------------------------------------------------------
// utc_datapath
// Field registers, floor carries through the divider, month stepping,
// leap-second fold-back and the response register.
// ----------------------------------------------------------------------------
module utc_datapath import utc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  dp_cmd_type         cmd,
   output dp_status_type      status,
   input  logic signed [15:0] sec_in,
   input  logic signed [15:0] min_in,
   input  logic signed [15:0] hour_in,
   input  logic signed [15:0] mday_in,
   input  logic signed [12:0] mon_in,
   input  logic signed [14:0] year_in,
   input  logic               leap_second_valid,
   input  logic               rsp_ready,
   output logic               rsp_valid,
   output logic [5:0]         sec_out,
   output logic [5:0]         min_out,
   output logic [4:0]         hour_out,
   output logic [4:0]         mday_out,
   output logic [3:0]         mon_out,
   output logic signed [15:0] year_out
);

   logic signed [15:0] sec_acc_ff, sec_acc_in;
   logic signed [16:0] min_acc_ff, min_acc_in;
   logic signed [16:0] hour_acc_ff, hour_acc_in;
   logic signed [16:0] day_acc_ff, day_acc_in;
   logic signed [12:0] mon_acc_ff, mon_acc_in;
   logic signed [15:0] yr_acc_ff, yr_acc_in;
   logic [8:0]         ymod_ff, ymod_in;
   logic               sec60_ff, sec60_in;
   logic               lsv_ff, lsv_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [5:0]         sec_o_ff, sec_o_in;
   logic [5:0]         min_o_ff, min_o_in;
   logic [4:0]         hour_o_ff, hour_o_in;
   logic [4:0]         day_o_ff, day_o_in;
   logic [3:0]         mon_o_ff, mon_o_in;
   logic signed [15:0] yr_o_ff, yr_o_in;

   logic [DIV_W-1:0]   dividend;
   logic [DIVR_W-1:0]  divisor;
   logic [MAG_W-1:0]   magic;
   logic [SHF_W-1:0]   shift;
   logic               div_done;
   logic [DIV_W-1:0]   div_quot;
   logic [DIVR_W-1:0]  div_rem;
   logic signed [17:0] qs;

   logic [3:0]         mon_cur;
   logic [3:0]         mon_prev;
   logic               leap;
   logic [4:0]         cur_len;
   logic [4:0]         prev_len;
   logic               day_low;
   logic               day_high;
   logic               ls_hit;
   logic               out_free;

   utc_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (dividend),
      .divisor  (divisor),
      .magic    (magic),
      .shift    (shift),
      .done     (div_done),
      .quot     (div_quot),
      .rem      (div_rem)
   );

   always_comb begin
      dividend = '0;
      divisor  = DVS_MINUTE;
      magic    = MAG_MINUTE;
      shift    = SHF_MINUTE;
      unique case (cmd.div_sel)
         DIV_SEC: begin
            dividend = DIV_W'(18'(sec_acc_ff) + OFS_60);
            divisor  = DVS_MINUTE;
            magic    = MAG_MINUTE;
            shift    = SHF_MINUTE;
         end
         DIV_MIN: begin
            dividend = DIV_W'(18'(min_acc_ff) + OFS_60);
            divisor  = DVS_MINUTE;
            magic    = MAG_MINUTE;
            shift    = SHF_MINUTE;
         end
         DIV_HOUR: begin
            dividend = DIV_W'(18'(hour_acc_ff) + OFS_24);
            divisor  = DVS_DAY;
            magic    = MAG_DAY;
            shift    = SHF_DAY;
         end
         DIV_MON: begin
            dividend = DIV_W'(18'(mon_acc_ff) + OFS_12);
            divisor  = DVS_YEAR;
            magic    = MAG_YEAR;
            shift    = SHF_YEAR;
         end
         DIV_YEAR: begin
            dividend = DIV_W'(18'(yr_acc_ff) + OFS_CYCLE);
            divisor  = DVS_CYCLE;
            magic    = MAG_CYCLE;
            shift    = SHF_CYCLE;
         end
         default: begin
            dividend = '0;
            divisor  = DVS_MINUTE;
            magic    = MAG_MINUTE;
            shift    = SHF_MINUTE;
         end
      endcase
   end

   assign qs = $signed({1'b0, div_quot});

   assign mon_cur  = mon_acc_ff[3:0];
   assign mon_prev = (mon_cur == MON_JAN) ? MON_DEC : mon_cur - 4'd1;
   assign leap     = (ymod_ff == '0) ||
                     (ymod_ff[1:0] == 2'b00 && ymod_ff != YMOD_C1 &&
                      ymod_ff != YMOD_C2 && ymod_ff != YMOD_C3);
   assign cur_len  = month_len(mon_cur, leap);
   assign prev_len = month_len(mon_prev, leap);
   assign day_low  = day_acc_ff < 17'sd1;
   assign day_high = day_acc_ff > $signed({12'd0, cur_len});

   assign ls_hit = sec60_ff && lsv_ff && sec_acc_ff == 16'sd0 && min_acc_ff == 17'sd0 &&
                   hour_acc_ff == 17'sd0 && day_acc_ff == 17'sd1 &&
                   (mon_cur == MON_JAN || mon_cur == MON_JUL);

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      sec_acc_in  = sec_acc_ff;
      min_acc_in  = min_acc_ff;
      hour_acc_in = hour_acc_ff;
      day_acc_in  = day_acc_ff;
      mon_acc_in  = mon_acc_ff;
      yr_acc_in   = yr_acc_ff;
      ymod_in     = ymod_ff;
      sec60_in    = sec60_ff;
      lsv_in      = lsv_ff;

      if (cmd.load) begin
         sec_acc_in  = sec_in;
         min_acc_in  = 17'(min_in);
         hour_acc_in = 17'(hour_in);
         day_acc_in  = 17'(mday_in);
         mon_acc_in  = mon_in;
         yr_acc_in   = 16'(year_in);
         sec60_in    = sec_in == 16'sd60;
         lsv_in      = leap_second_valid;
      end else if (cmd.commit) begin
         unique case (cmd.div_sel)
            DIV_SEC: begin
               sec_acc_in = 16'(div_rem);
               min_acc_in = 17'(18'(min_acc_ff) + qs - BIAS_60);
            end
            DIV_MIN: begin
               min_acc_in  = 17'(div_rem);
               hour_acc_in = 17'(18'(hour_acc_ff) + qs - BIAS_60);
            end
            DIV_HOUR: begin
               hour_acc_in = 17'(div_rem);
               day_acc_in  = 17'(18'(day_acc_ff) + qs - BIAS_24);
            end
            DIV_MON: begin
               mon_acc_in = 13'(div_rem);
               yr_acc_in  = 16'(18'(yr_acc_ff) + qs - BIAS_12);
            end
            DIV_YEAR: begin
               ymod_in = div_rem;
            end
            default: begin
               ymod_in = ymod_ff;
            end
         endcase
      end else if (cmd.step) begin
         if (day_low) begin
            day_acc_in = day_acc_ff + $signed({12'd0, prev_len});
            mon_acc_in = 13'(mon_prev);
            if (mon_cur == MON_JAN) begin
               yr_acc_in = yr_acc_ff - 16'sd1;
               ymod_in   = (ymod_ff == '0) ? YMOD_LAST : ymod_ff - 9'd1;
            end
         end else if (day_high) begin
            day_acc_in = day_acc_ff - $signed({12'd0, cur_len});
            if (mon_cur == MON_DEC) begin
               mon_acc_in = 13'(MON_JAN);
               yr_acc_in  = yr_acc_ff + 16'sd1;
               ymod_in    = (ymod_ff == YMOD_LAST) ? 9'd0 : ymod_ff + 9'd1;
            end else begin
               mon_acc_in = 13'(mon_cur + 4'd1);
            end
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      sec_o_in     = sec_o_ff;
      min_o_in     = min_o_ff;
      hour_o_in    = hour_o_ff;
      day_o_in     = day_o_ff;
      mon_o_in     = mon_o_ff;
      yr_o_in      = yr_o_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
         if (ls_hit) begin
            sec_o_in  = 6'd60;
            min_o_in  = 6'd59;
            hour_o_in = 5'd23;
            if (mon_cur == MON_JAN) begin
               day_o_in = 5'd31;
               mon_o_in = MON_DEC;
               yr_o_in  = yr_acc_ff - 16'sd1;
            end else begin
               day_o_in = 5'd30;
               mon_o_in = MON_JUN;
               yr_o_in  = yr_acc_ff;
            end
         end else begin
            sec_o_in  = sec_acc_ff[5:0];
            min_o_in  = min_acc_ff[5:0];
            hour_o_in = hour_acc_ff[4:0];
            day_o_in  = day_acc_ff[4:0];
            mon_o_in  = mon_cur;
            yr_o_in   = yr_acc_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      sec_acc_ff  <= sec_acc_in;
      min_acc_ff  <= min_acc_in;
      hour_acc_ff <= hour_acc_in;
      day_acc_ff  <= day_acc_in;
      mon_acc_ff  <= mon_acc_in;
      yr_acc_ff   <= yr_acc_in;
      ymod_ff     <= ymod_in;
      sec60_ff    <= sec60_in;
      lsv_ff      <= lsv_in;
      sec_o_ff    <= sec_o_in;
      min_o_ff    <= min_o_in;
      hour_o_ff   <= hour_o_in;
      day_o_ff    <= day_o_in;
      mon_o_ff    <= mon_o_in;
      yr_o_ff     <= yr_o_in;
   end

   assign status.div_done  = div_done;
   assign status.norm_done = !day_low && !day_high;
   assign status.out_free  = out_free;

   assign rsp_valid = rsp_valid_ff;
   assign sec_out   = sec_o_ff;
   assign min_out   = min_o_ff;
   assign hour_out  = hour_o_ff;
   assign mday_out  = day_o_ff;
   assign mon_out   = mon_o_ff;
   assign year_out  = yr_o_ff;

endmodule

FILE: rtl/utc_controller.sv
// ----------------------------------------------------------------------------
// utc_controller
// Sequences the five floor divisions, the month stepping loop and the
// hand-off into the response register.
// ----------------------------------------------------------------------------
module utc_controller import utc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   localparam logic [2:0] ST_IDLE      = 3'd0;
   localparam logic [2:0] ST_DIV_START = 3'd1;
   localparam logic [2:0] ST_DIV_WAIT  = 3'd2;
   localparam logic [2:0] ST_LOOP      = 3'd3;
   localparam logic [2:0] ST_OUT       = 3'd4;

   logic [2:0] state_ff, state_in;
   logic [2:0] sel_ff, sel_in;
   logic [2:0] sel_next;

   always_comb begin
      case (sel_ff)
         DIV_SEC:  sel_next = DIV_MIN;
         DIV_MIN:  sel_next = DIV_HOUR;
         DIV_HOUR: sel_next = DIV_MON;
         DIV_MON:  sel_next = DIV_YEAR;
         default:  sel_next = DIV_SEC;
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      sel_in        = sel_ff;
      cmd           = '0;
      cmd.div_sel   = sel_ff;
      req_ready     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               sel_in   = DIV_SEC;
               state_in = ST_DIV_START;
            end
         end
         ST_DIV_START: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (status.div_done) begin
               cmd.commit = 1'b1;
               if (sel_ff == DIV_YEAR) begin
                  state_in = ST_LOOP;
               end else begin
                  sel_in   = sel_next;
                  state_in = ST_DIV_START;
               end
            end
         end
         ST_LOOP: begin
            if (status.norm_done) begin
               state_in = ST_OUT;
            end else begin
               cmd.step = 1'b1;
            end
         end
         ST_OUT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         sel_ff   <= DIV_SEC;
      end else begin
         state_ff <= state_in;
         sel_ff   <= sel_in;
      end
   end

endmodule

FILE: rtl/utc_date_time_normalizer_top.sv
// ----------------------------------------------------------------------------
// utc_date_time_normalizer_top
// Normalizes one broken-down UTC date-time per request word.
//
//   channel  dir  words                      handshake
//   req_ch   in   raw date-time + leap flag  valid/ready
//   rsp_ch   out  normalized date-time       valid/ready
//
// One word in flight: accept, five floor divisions through one shared
// reciprocal-multiply divider, a loop that steps one month at a time until
// the day fits its month (up to roughly 1130 month steps), then the hand-off.
// A response waiting on rsp_ch does not block the next request; the hand-off
// of a finished word waits until the response register is free.
// Synchronous reset clears the sequencer, divider control and response valid.
// ----------------------------------------------------------------------------
module utc_date_time_normalizer_top import utc_pkg::*; (
   input logic       clock,
   input logic       reset,
   utc_req_if.sink   req_ch,
   utc_rsp_if.source rsp_ch
);

   dp_cmd_type    cmd;
   dp_status_type status;
   logic          req_ready;
   logic          rsp_valid;

   utc_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   utc_datapath u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .sec_in            (req_ch.sec_in),
      .min_in            (req_ch.min_in),
      .hour_in           (req_ch.hour_in),
      .mday_in           (req_ch.mday_in),
      .mon_in            (req_ch.mon_in),
      .year_in           (req_ch.year_in),
      .leap_second_valid (req_ch.leap_second_valid),
      .rsp_ready         (rsp_ch.ready),
      .rsp_valid         (rsp_valid),
      .sec_out           (rsp_ch.sec_out),
      .min_out           (rsp_ch.min_out),
      .hour_out          (rsp_ch.hour_out),
      .mday_out          (rsp_ch.mday_out),
      .mon_out           (rsp_ch.mon_out),
      .year_out          (rsp_ch.year_out)
   );

   assign req_ch.ready = req_ready;
   assign rsp_ch.valid = rsp_valid;

endmodule

FILE: tb/sv/utc_date_time_normalizer_top_tb.sv
// ----------------------------------------------------------------------------
// utc_date_time_normalizer_top_tb
// Self-checking bench for the UTC date-time normalizer. Drives request words
// through the valid/ready request channel and predicts each normalized word:
// floor carries of seconds, minutes and hours, month-by-month day folding
// under the Gregorian leap rule, and the leap-second fold back to 23:59:60.
// Directed words cover in-range dates, carries, field extremes and leap
// seconds. Random words then run under three idling mixes on both channels.
// ----------------------------------------------------------------------------
module utc_date_time_normalizer_top_tb import utc_pkg::*; ();

   localparam int CYCLE_LIMIT   = 4_000_000;
   localparam int WORD_LATENCY  = 1300;
   localparam int MONTH_YEAR    = 12;
   localparam int SEC_MIN       = 60;
   localparam int HOUR_DAY      = 24;
   localparam int BASE_YEAR     = 1900;

   typedef struct packed {
      logic signed [15:0] sec;
      logic signed [15:0] min;
      logic signed [15:0] hour;
      logic signed [15:0] mday;
      logic signed [12:0] mon;
      logic signed [14:0] year;
      logic               leap_ok;
   } date_req_type;

   typedef struct packed {
      logic [5:0]         sec;
      logic [5:0]         min;
      logic [4:0]         hour;
      logic [4:0]         mday;
      logic [3:0]         mon;
      logic signed [15:0] year;
   } date_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   utc_req_if req_ch ();
   utc_rsp_if rsp_ch ();

   utc_date_time_normalizer_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   date_rsp_type expected_dates[$];
   date_rsp_type want_date;
   date_rsp_type seen_date;
   int           send_idle_pct = 0;
   int           recv_idle_pct = 0;
   int           mismatches    = 0;
   int           cycles        = 0;
   int           directed_sent = 0;
   int           random_sent   = 0;
   int           leap_folds    = 0;
   logic         in_random     = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   function automatic int carry_floor(inout int v, input int base);
      int q;
      int r;
      q = v / base;
      r = v % base;
      if (r < 0) begin
         r += base;
         q -= 1;
      end
      v = r;
      return q;
   endfunction

   function automatic logic gregorian_leap(int y);
      if (y % 400 == 0) return 1'b1;
      if (y % 100 == 0) return 1'b0;
      return (y % 4 == 0);
   endfunction

   function automatic int days_in_month(int m, logic leap);
      case (m)
         1: begin
            return leap ? 29 : 28;
         end
         3, 5, 8, 10: begin
            return 30;
         end
         default: begin
            return 31;
         end
      endcase
   endfunction

   function automatic date_rsp_type predict_date(date_req_type w);
      int           sec;
      int           min;
      int           hour;
      int           day;
      int           mon;
      int           yr;
      logic         leap;
      date_rsp_type r;
      sec  = w.sec;
      min  = w.min;
      hour = w.hour;
      day  = w.mday;
      mon  = w.mon;
      yr   = int'(w.year) + BASE_YEAR;
      min  += carry_floor(sec, SEC_MIN);
      hour += carry_floor(min, SEC_MIN);
      day  += carry_floor(hour, HOUR_DAY);
      leap = gregorian_leap(yr);
      while (mon > 11 || mon < 0 || day < 1 || day > days_in_month(mon, leap)) begin
         while (mon < 0) begin
            mon += MONTH_YEAR;
            yr--;
         end
         while (mon > 11) begin
            mon -= MONTH_YEAR;
            yr++;
         end
         leap = gregorian_leap(yr);
         if (day < 1) begin
            day += days_in_month((mon + 11) % MONTH_YEAR, leap);
            mon--;
         end else if (day > days_in_month(mon, leap)) begin
            day -= days_in_month(mon, leap);
            mon++;
         end
      end
      if (w.sec == 16'sd60 && sec == 0 && min == 0 && hour == 0 && day == 1
          && (mon == MON_JAN || mon == MON_JUL) && w.leap_ok) begin
         sec  = 60;
         min  = 59;
         hour = 23;
         if (mon == MON_JAN) begin
            day = 31;
            mon = MON_DEC;
            yr--;
         end else begin
            day = 30;
            mon = MON_JUN;
         end
      end
      r.sec  = sec[5:0];
      r.min  = min[5:0];
      r.hour = hour[4:0];
      r.mday = day[4:0];
      r.mon  = mon[3:0];
      r.year = 16'(yr - BASE_YEAR);
      return r;
   endfunction

   function automatic date_req_type make_date(int s, int mi, int h, int d, int mo, int y,
                                              logic lsv);
      date_req_type w;
      w.sec     = 16'(s);
      w.min     = 16'(mi);
      w.hour    = 16'(h);
      w.mday    = 16'(d);
      w.mon     = 13'(mo);
      w.year    = 15'(y);
      w.leap_ok = lsv;
      return w;
   endfunction

   function automatic int rand_between(int lo, int hi);
      return lo + int'($urandom_range(0, hi - lo));
   endfunction

   // result checker and receiver idling
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         seen_date.sec  = rsp_ch.sec_out;
         seen_date.min  = rsp_ch.min_out;
         seen_date.hour = rsp_ch.hour_out;
         seen_date.mday = rsp_ch.mday_out;
         seen_date.mon  = rsp_ch.mon_out;
         seen_date.year = rsp_ch.year_out;
         if (expected_dates.size() == 0) begin
            mismatches++;
            $display("%0t: result word with none expected: %0d:%0d:%0d %0d/%0d/%0d", $time,
                     seen_date.hour, seen_date.min, seen_date.sec, seen_date.mday,
                     seen_date.mon, seen_date.year);
         end else begin
            want_date = expected_dates.pop_front();
            if (want_date.sec !== seen_date.sec || want_date.min !== seen_date.min
                || want_date.hour !== seen_date.hour || want_date.mday !== seen_date.mday
                || want_date.mon !== seen_date.mon || want_date.year !== seen_date.year) begin
               mismatches++;
               $display("%0t: mismatch exp %0d:%0d:%0d %0d/%0d/%0d got %0d:%0d:%0d %0d/%0d/%0d",
                        $time, want_date.hour, want_date.min, want_date.sec, want_date.mday,
                        want_date.mon, want_date.year, seen_date.hour, seen_date.min,
                        seen_date.sec, seen_date.mday, seen_date.mon, seen_date.year);
            end
         end
      end
      rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   task automatic send_date(input date_req_type w);
      date_rsp_type r;
      if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < send_idle_pct);
      end
      req_ch.valid             <= 1'b1;
      req_ch.sec_in            <= w.sec;
      req_ch.min_in            <= w.min;
      req_ch.hour_in           <= w.hour;
      req_ch.mday_in           <= w.mday;
      req_ch.mon_in            <= w.mon;
      req_ch.year_in           <= w.year;
      req_ch.leap_second_valid <= w.leap_ok;
      do @(posedge clock); while (!req_ch.ready);
      r = predict_date(w);
      expected_dates.push_back(r);
      if (r.sec == 6'd60) leap_folds++;
      if (in_random) random_sent++;
      else directed_sent++;
   endtask

   // hold off new words until every result word is back
   task automatic drain_results();
      req_ch.valid <= 1'b0;
      while (expected_dates.size() != 0) @(posedge clock);
   endtask

   task automatic test_plain_dates();
      send_date(make_date(56, 34, 12, 17, 4, 124, 1'b0));
      send_date(make_date(0, 0, 0, 29, MON_FEB, 100, 1'b1));
      send_date(make_date(59, 59, 23, 29, MON_FEB, 0, 1'b0));
      send_date(make_date(30, 30, 6, 29, MON_FEB, 200, 1'b1));
      send_date(make_date(1, 2, 3, 29, MON_FEB, 96, 1'b0));
   endtask

   task automatic test_floor_carries();
      send_date(make_date(-1, -1, -1, 1, 0, 70, 1'b0));
      send_date(make_date(3600, 0, 0, 1, 0, 70, 1'b1));
      send_date(make_date(0, 0, 0, 0, 0, 70, 1'b0));
      send_date(make_date(0, 0, 0, 32, 0, 70, 1'b0));
      send_date(make_date(0, 0, 0, 1, -1, 70, 1'b1));
      send_date(make_date(0, 0, 0, 1, 12, 70, 1'b0));
      send_date(make_date(0, 0, 0, -365, 0, 70, 1'b0));
   endtask

   task automatic test_field_extremes();
      send_date(make_date(-32768, -32768, -32768, -32768, -4096, -16384, 1'b1));
      send_date(make_date(32767, 32767, 32767, 32767, 4095, 16383, 1'b1));
      send_date(make_date(-32768, 32767, 32767, 32767, 4095, -16384, 1'b0));
      send_date(make_date(32767, -32768, -32768, -32768, -4096, 16383, 1'b0));
   endtask

   task automatic test_leap_seconds();
      send_date(make_date(60, 59, 23, 31, MON_DEC, 116, 1'b1));
      send_date(make_date(60, 59, 23, 31, MON_DEC, 116, 1'b0));
      send_date(make_date(60, 59, 23, 30, MON_JUN, 115, 1'b1));
      send_date(make_date(60, 59, 23, 30, MON_JUN, 115, 1'b0));
      send_date(make_date(60, 59, 23, 31, 2, 115, 1'b1));
      send_date(make_date(60, -1, 0, 1, MON_JAN, 99, 1'b1));
      send_date(make_date(0, 0, 0, 1, MON_JAN, 99, 1'b1));
      send_date(make_date(120, 58, 23, 31, MON_DEC, 99, 1'b1));
   endtask

   task automatic test_random_dates(input int count);
      date_req_type w;
      int           pick;
      int           shape;
      in_random = 1'b1;
      repeat (count) begin
         pick      = $urandom_range(0, 99);
         w.year    = 15'(rand_between(-16384, 16383));
         w.leap_ok = 1'($urandom_range(0, 1));
         if (pick < 45) begin
            w.sec  = 16'(rand_between(-90, 150));
            w.min  = 16'(rand_between(-90, 150));
            w.hour = 16'(rand_between(-30, 50));
            w.mday = 16'(rand_between(-40, 70));
            w.mon  = 13'(rand_between(-15, 26));
         end else if (pick < 65) begin
            // leap-second candidates, some reached only through day folding
            shape  = $urandom_range(0, 4);
            w.sec  = 16'sd60;
            w.min  = 16'sd59;
            w.hour = 16'sd23;
            case (shape)
               0: begin
                  w.mday = 16'sd30;
                  w.mon  = 13'(MON_JUN);
               end
               1: begin
                  w.mday = 16'sd31;
                  w.mon  = 13'(MON_DEC);
               end
               2: begin
                  w.mday = 16'sd0;
                  w.mon  = 13'(MON_JUL);
               end
               3: begin
                  w.mday = 16'sd0;
                  w.mon  = 13'sd12;
               end
               default: begin
                  w.mday = 16'sd31;
                  w.mon  = -13'sd1;
               end
            endcase
         end else if (pick < 85) begin
            w.sec  = 16'(rand_between(-2000, 2000));
            w.min  = 16'(rand_between(-2000, 2000));
            w.hour = 16'(rand_between(-2000, 2000));
            w.mday = 16'(rand_between(-1000, 1000));
            w.mon  = 13'(rand_between(-100, 100));
         end else begin
            w.sec  = 16'($urandom());
            w.min  = 16'($urandom());
            w.hour = 16'($urandom());
            w.mday = 16'($urandom());
            w.mon  = 13'($urandom());
         end
         send_date(w);
      end
   endtask

   initial begin
      req_ch.valid             <= 1'b0;
      req_ch.sec_in            <= '0;
      req_ch.min_in            <= '0;
      req_ch.hour_in           <= '0;
      req_ch.mday_in           <= '0;
      req_ch.mon_in            <= '0;
      req_ch.year_in           <= '0;
      req_ch.leap_second_valid <= 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 29;
      recv_idle_pct = 84;
      test_plain_dates();
      test_floor_carries();
      test_field_extremes();
      test_leap_seconds();
      drain_results();

      test_random_dates(150);
      drain_results();
      send_idle_pct = 84;
      recv_idle_pct = 29;
      test_random_dates(150);
      drain_results();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_dates(160);

      drain_results();
      repeat (WORD_LATENCY) @(posedge clock);

      $display("Sent %0d directed and %0d random date-time words under three idling mixes,",
               directed_sent, random_sent);
      $display("%0d of them folded back to a leap second; %0d mismatches.",
               leap_folds, mismatches);
      if (mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

FILE: utc_date_time_normalizer_top.f
rtl/utc_pkg.sv
rtl/utc_if.sv
rtl/utc_divider.sv
rtl/utc_datapath.sv
rtl/utc_controller.sv
rtl/utc_date_time_normalizer_top.sv
tb/sv/utc_date_time_normalizer_top_tb.sv
